// ===== design/fbfl_pkg.sv =====
// Shared types and constants for the fixed block free list allocator.
`default_nettype none
package fbfl_pkg;

  localparam int SLOT_W  = 10;
  localparam int BYTES_W = 23;
  localparam int OBJ_W   = 13;
  localparam int MODE_W  = 2;

  localparam logic [BYTES_W-1:0] BYTES_MAX     = '1;
  localparam logic [OBJ_W-1:0]   OBJ_SIZE_RST  = 13'd8;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ENGAGE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_ALLOC_UPD,
    ST_FREE_WR,
    ST_DIV,
    ST_CLAMP,
    ST_WALK,
    ST_DONE
  } fbfl_state_t;

endpackage
`default_nettype wire

// ===== design/fixed_block_free_list_core.sv =====
// Top level of the fixed block free list allocator: sequencer, link memory, divider.
//
// Usage:
//   Command channel: drive in_mode, in_slot, in_region_bytes and raise start;
//   the command transfers on a rising edge with start high and busy low.
//   busy stays high until the command has finished.
//   Result channel: out_valid pulses for one cycle with out_alloc_slot,
//   out_was_empty and out_free_bytes. The receiver cannot stall; every
//   result must be taken in its cycle.
//   Config channel: cfg_obj_size transfers when cfg_valid and cfg_ready are
//   high; cfg_ready is high only while the block is idle.
// Sequence (start transfer to out_valid):
//   allocate reads the link at head, then updates head and count (an empty
//   list goes straight to the result); free writes one link for an in-range
//   slot; engage runs a restoring divider for region_bytes / obj_size, a clamp
//   step, then one link memory write per slot. Unused mode goes straight to the result.
//   A new command may start in the cycle out_valid is high.
// Reset (synchronous, active low): list empty, head 0, obj_size 8. The link
//   memory is not cleared; only written links are ever read.
`default_nettype none
module fixed_block_free_list_core
  import fbfl_pkg::*;
#(
  parameter int POOL_SLOTS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [SLOT_W-1:0]  in_slot,
  input  wire logic [BYTES_W-1:0] in_region_bytes,
  output      logic               out_valid,
  output      logic [SLOT_W-1:0]  out_alloc_slot,
  output      logic               out_was_empty,
  output      logic [BYTES_W-1:0] out_free_bytes,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [OBJ_W-1:0]   cfg_obj_size
);

  localparam int AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int PW = CW + OBJ_W;
  localparam int MW = (PW > BYTES_W) ? PW : BYTES_W;
  localparam int DCW = $clog2(BYTES_W + 1);
  localparam logic [CW:0] POOL_C = (CW+1)'(POOL_SLOTS);

  fbfl_state_t state_r, state_nxt;

  logic [SLOT_W-1:0]  mem [POOL_SLOTS];
  logic [SLOT_W-1:0]  rd_data_r;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [SLOT_W-1:0]  wr_data;

  logic [OBJ_W-1:0]   obj_size_r;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [BYTES_W-1:0] quot_r, quot_nxt;
  logic [OBJ_W-1:0]   rem_r, rem_nxt;
  logic [DCW-1:0]     div_cnt_r, div_cnt_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      walk_r, walk_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [SLOT_W-1:0]  got_r, got_nxt;
  logic               empty_r, empty_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic               out_empty_r, out_empty_nxt;
  logic [BYTES_W-1:0] out_bytes_r, out_bytes_nxt;

  logic [XW-1:0]      head_x, slot_x;
  logic [XW:0]        ptr_inc;
  logic [OBJ_W:0]     trial;
  logic [CW:0]        limit;
  logic [CW:0]        sum;
  logic [CW-1:0]      count_add;
  logic [PW-1:0]      prod;
  logic [MW-1:0]      prod_x;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;

  assign out_valid      = out_valid_r;
  assign out_alloc_slot = out_slot_r;
  assign out_was_empty  = out_empty_r;
  assign out_free_bytes = out_bytes_r;

  assign head_x    = XW'(head_r);
  assign slot_x    = XW'(slot_r);
  assign ptr_inc   = (XW+1)'(ptr_r) + (XW+1)'(1);
  assign trial     = {rem_r, quot_r[BYTES_W-1]} - (OBJ_W+1)'(obj_size_r);
  assign limit     = POOL_C - (CW+1)'(slot_x);
  assign count_add = (state_r == ST_FREE_WR) ? CW'(1) : n_r;
  assign sum       = (CW+1)'(count_r) + (CW+1)'(count_add);
  assign prod      = PW'(count_r) * PW'(obj_size_r);
  assign prod_x    = MW'(prod);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[head_x[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      obj_size_r  <= OBJ_SIZE_RST;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        obj_size_r <= cfg_obj_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    quot_r      <= quot_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    ptr_r       <= ptr_nxt;
    walk_r      <= walk_nxt;
    n_r         <= n_nxt;
    got_r       <= got_nxt;
    empty_r     <= empty_nxt;
    out_slot_r  <= out_slot_nxt;
    out_empty_r <= out_empty_nxt;
    out_bytes_r <= out_bytes_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    ptr_nxt       = ptr_r;
    walk_nxt      = walk_r;
    n_nxt         = n_r;
    got_nxt       = got_r;
    empty_nxt     = empty_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_empty_nxt = out_empty_r;
    out_bytes_nxt = out_bytes_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = head_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          slot_nxt  = in_slot;
          quot_nxt  = in_region_bytes;
          rem_nxt   = '0;
          div_cnt_nxt = DCW'(BYTES_W);
          got_nxt   = '0;
          empty_nxt = 1'b0;
          case (in_mode)
            MODE_ALLOC: begin
              if (count_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_ALLOC_RD;
              end
            end
            MODE_FREE:   state_nxt = ST_FREE_WR;
            MODE_ENGAGE: state_nxt = ST_DIV;
            default:     state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ALLOC_RD: begin
        got_nxt   = head_r;
        state_nxt = ST_ALLOC_UPD;
      end
      ST_ALLOC_UPD: begin
        head_nxt  = rd_data_r;
        count_nxt = count_r - CW'(1);
        state_nxt = ST_DONE;
      end
      ST_FREE_WR: begin
        if ((XW+1)'(slot_x) < (XW+1)'(POOL_SLOTS)) begin
          wr_en     = 1'b1;
          wr_addr   = slot_x[AW-1:0];
          wr_data   = head_r;
          head_nxt  = slot_r;
          count_nxt = (sum > POOL_C) ? CW'(POOL_SLOTS) : sum[CW-1:0];
        end
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        if (!trial[OBJ_W]) begin
          rem_nxt  = trial[OBJ_W-1:0];
          quot_nxt = {quot_r[BYTES_W-2:0], 1'b1};
        end else begin
          rem_nxt  = {rem_r[OBJ_W-2:0], quot_r[BYTES_W-1]};
          quot_nxt = {quot_r[BYTES_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r - DCW'(1);
        if (div_cnt_r == DCW'(1)) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        ptr_nxt = slot_x[AW-1:0];
        if (obj_size_r == '0 || (XW+1)'(slot_x) >= (XW+1)'(POOL_SLOTS)) begin
          n_nxt = '0;
        end else if (32'(quot_r) > 32'(limit)) begin
          n_nxt = limit[CW-1:0];
        end else begin
          n_nxt = CW'(quot_r);
        end
        walk_nxt  = n_nxt;
        state_nxt = (n_nxt == '0) ? ST_DONE : ST_WALK;
      end
      ST_WALK: begin
        wr_en    = 1'b1;
        wr_addr  = ptr_r;
        ptr_nxt  = ptr_inc[AW-1:0];
        walk_nxt = walk_r - CW'(1);
        if (walk_r == CW'(1)) begin
          wr_data   = head_r;
          head_nxt  = slot_r;
          count_nxt = (sum > POOL_C) ? CW'(POOL_SLOTS) : sum[CW-1:0];
          state_nxt = ST_DONE;
        end else begin
          wr_data = ptr_inc[SLOT_W-1:0];
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_slot_nxt  = got_r;
        out_empty_nxt = empty_r;
        out_bytes_nxt = (prod_x > MW'(BYTES_MAX)) ? BYTES_MAX : prod_x[BYTES_W-1:0];
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/fbfl_checker.sv =====
// Port-level checker for the free list allocator, bound to the top level.
`default_nettype none
module fbfl_checker
  import fbfl_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic [SLOT_W-1:0]  out_alloc_slot,
  input wire logic               out_was_empty,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_empty |-> out_alloc_slot == '0)
    else $error("empty allocate returned nonzero slot");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !busy)
    else $error("config transfer while busy");

endmodule

bind fixed_block_free_list_core fbfl_checker u_fbfl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_alloc_slot (out_alloc_slot),
  .out_was_empty  (out_was_empty),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready)
);
`default_nettype wire

// ===== tb/tb_fixed_block_free_list_core.sv =====
// Testbench for fixed_block_free_list_core: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
module tb_fixed_block_free_list_core;
  import fbfl_pkg::*;

  localparam int POOL_SLOTS = 1024;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic               was_empty;
    logic [BYTES_W-1:0] free_bytes;
  } alloc_result_t;

  class free_list_tracker #(int POOL = 1024);
    logic [SLOT_W-1:0] link_mem [POOL];
    logic [SLOT_W-1:0] head;
    int unsigned       free_slots;
    logic [OBJ_W-1:0]  obj_bytes;
    alloc_result_t     expected_results [$];
    logic [SLOT_W-1:0] handed_out [$];
    int unsigned       mismatches;

    function new();
      foreach (link_mem[i]) link_mem[i] = '0;
      head = '0;
      free_slots = 0;
      obj_bytes = OBJ_SIZE_RST;
      mismatches = 0;
    endfunction

    function void set_obj_size(logic [OBJ_W-1:0] v);
      obj_bytes = v;
    endfunction

    function void grow(int unsigned n);
      free_slots = (free_slots + n > POOL) ? POOL : free_slots + n;
    endfunction

    function void note_command(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot,
                               logic [BYTES_W-1:0] region);
      alloc_result_t r;
      int unsigned n;
      int unsigned i;
      longint unsigned b;
      r = '0;
      case (mode)
        MODE_ALLOC: begin
          if (free_slots == 0) begin
            r.was_empty = 1'b1;
          end else begin
            r.slot = head;
            head = link_mem[head];
            free_slots--;
            handed_out.push_back(r.slot);
          end
        end
        MODE_FREE: begin
          link_mem[slot] = head;
          head = slot;
          grow(1);
        end
        MODE_ENGAGE: begin
          n = (obj_bytes == 0) ? 0 : region / obj_bytes;
          if (n > POOL - slot) n = POOL - slot;
          if (n > 0) begin
            for (i = 0; i + 1 < n; i++) link_mem[slot + i] = SLOT_W'(slot + i + 1);
            link_mem[slot + n - 1] = head;
            head = slot;
            grow(n);
          end
        end
        default: ;
      endcase
      b = longint'(free_slots) * obj_bytes;
      if (b > BYTES_MAX) b = BYTES_MAX;
      r.free_bytes = b[BYTES_W-1:0];
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [SLOT_W-1:0] slot, logic empty, logic [BYTES_W-1:0] bytes);
      alloc_result_t e;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: slot %0d empty %0b bytes %0d",
                                  slot, empty, bytes));
      end else begin
        e = expected_results.pop_front();
        if (slot !== e.slot)
          report_mismatch($sformatf("alloc_slot %0d, want %0d", slot, e.slot));
        if (empty !== e.was_empty)
          report_mismatch($sformatf("was_empty %0b, want %0b", empty, e.was_empty));
        if (bytes !== e.free_bytes)
          report_mismatch($sformatf("free_bytes %0d, want %0d", bytes, e.free_bytes));
      end
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [MODE_W-1:0]  in_mode;
  logic [SLOT_W-1:0]  in_slot;
  logic [BYTES_W-1:0] in_region_bytes;
  logic               out_valid;
  logic [SLOT_W-1:0]  out_alloc_slot;
  logic               out_was_empty;
  logic [BYTES_W-1:0] out_free_bytes;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [OBJ_W-1:0]   cfg_obj_size;

  free_list_tracker #(POOL_SLOTS) sb;

  fixed_block_free_list_core #(
    .POOL_SLOTS(POOL_SLOTS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_slot        (in_slot),
    .in_region_bytes(in_region_bytes),
    .out_valid      (out_valid),
    .out_alloc_slot (out_alloc_slot),
    .out_was_empty  (out_was_empty),
    .out_free_bytes (out_free_bytes),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_obj_size   (cfg_obj_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL fixed_block_free_list_core");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_alloc_slot, out_was_empty, out_free_bytes);
  end

  // Idle for a random gap, then hold the command until it transfers.
  task issue(logic [MODE_W-1:0] mode, logic [SLOT_W-1:0] slot, logic [BYTES_W-1:0] region,
             int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= mode;
    in_slot <= slot;
    in_region_bytes <= region;
    do @(posedge clk); while (busy);
    sb.note_command(mode, slot, region);
  endtask

  task drain();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task write_obj_size(logic [OBJ_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_obj_size <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_obj_size(v);
    cfg_valid <= 1'b0;
  endtask

  task pick_command(output logic [MODE_W-1:0] mode, output logic [SLOT_W-1:0] slot,
                    output logic [BYTES_W-1:0] region);
    int unsigned sel;
    int unsigned idx;
    int unsigned k;
    int unsigned obj;
    sel = $urandom_range(0, 99);
    slot = SLOT_W'($urandom);
    region = BYTES_W'($urandom);
    obj = sb.obj_bytes;
    if (sel < 5) begin
      mode = MODE_UNUSED;
    end else if (sel < 45) begin
      mode = MODE_ALLOC;
    end else if (sel < 70) begin
      mode = MODE_FREE;
      if (sb.handed_out.size() != 0 && $urandom_range(0, 9) < 7) begin
        idx = $urandom_range(0, sb.handed_out.size() - 1);
        slot = sb.handed_out[idx];
        sb.handed_out.delete(idx);
      end
    end else begin
      mode = MODE_ENGAGE;
      sel = $urandom_range(0, 99);
      if (sel < 85) begin
        k = $urandom_range(0, 12);
        region = BYTES_W'(k * obj + ((obj == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, obj - 1)));
      end else if (sel < 95) begin
        slot = SLOT_W'($urandom_range(990, 1023));
      end
    end
  endtask

  initial begin
    logic [OBJ_W-1:0]   phase_obj [RANDOM_PHASES];
    int unsigned        phase_idle [RANDOM_PHASES];
    logic [MODE_W-1:0]  m;
    logic [SLOT_W-1:0]  s;
    logic [BYTES_W-1:0] rb;
    sb = new();
    phase_obj = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd3, OBJ_W'($urandom_range(1, 4096))};
    phase_idle = '{27, 27, 77, 77, 0, 0};
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_ALLOC;
    in_slot <= '0;
    in_region_bytes <= '0;
    cfg_valid <= 1'b0;
    cfg_obj_size <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, object size at its reset value
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_UNUSED, 10'd1023, BYTES_MAX, 27);
    issue(MODE_ENGAGE, 10'd5, 23'd0, 27);
    issue(MODE_ENGAGE, 10'd5, 23'd7, 27);
    issue(MODE_ENGAGE, 10'd1020, 23'd80, 27);
    issue(MODE_ALLOC, 10'd1023, BYTES_MAX, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_FREE, 10'd0, 23'd0, 27);
    issue(MODE_FREE, 10'd1023, BYTES_MAX, 27);
    issue(MODE_ENGAGE, 10'd0, BYTES_MAX, 27);
    issue(MODE_FREE, 10'd512, 23'd4194304, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_ENGAGE, 10'd1023, 23'd8, 27);
    issue(MODE_ENGAGE, 10'd1023, 23'd16, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_ALLOC, 10'd0, 23'd0, 27);
    issue(MODE_UNUSED, 10'd0, 23'd0, 27);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_obj_size(phase_obj[p]);
      repeat (PHASE_ITEMS) begin
        pick_command(m, s, rb);
        issue(m, s, rb, phase_idle[p]);
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (sb.expected_results.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_results.size()));
    if (sb.mismatches == 0) begin
      $display("PASS fixed_block_free_list_core");
    end else begin
      $display("FAIL fixed_block_free_list_core");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/fbfl_pkg.sv
design/fixed_block_free_list_core.sv
design/fbfl_checker.sv
tb/tb_fixed_block_free_list_core.sv
